### sv/vmb_pkg.sv
package vmb_pkg;

    localparam logic [2:0] REG_SENS_GAIN  = 3'd0;
    localparam logic [2:0] REG_RISE_STEP  = 3'd1;
    localparam logic [2:0] REG_FALL_STEP  = 3'd2;
    localparam logic [2:0] REG_PROP_COEFF = 3'd3;
    localparam logic [2:0] REG_INT_COEFF  = 3'd4;

    localparam logic [14:0] SENS_GAIN_RST  = 15'd18483;
    localparam logic [15:0] RISE_STEP_RST  = 16'd1831;
    localparam logic [15:0] FALL_STEP_RST  = 16'd582;
    localparam logic [15:0] PROP_COEFF_RST = 16'd1966;
    localparam logic [15:0] INT_COEFF_RST  = 16'd33;

    localparam int PEAK_W  = 24;
    localparam int INTEG_W = 24;
    localparam int QUO_W   = 17;
    localparam int PROD_W  = 41;
    localparam int STEP_W  = 42;
    localparam int NP_W    = 27;

    localparam int DIV_STEPS = QUO_W;

    localparam logic signed [24:0] INTEG_MAX = 25'sd8388607;
    localparam logic signed [24:0] INTEG_MIN = -25'sd8388608;
    localparam logic signed [NP_W-1:0] NP_FULL = 27'sd32768;
    localparam logic [15:0] FULL_SCALE = 16'd32768;

    typedef struct packed {
        logic [14:0] sens_gain;
        logic [15:0] rise_step;
        logic [15:0] fall_step;
        logic [15:0] prop_coeff;
        logic [15:0] int_coeff;
    } cfg_t;

    typedef struct packed {
        logic load_prod;
        logic slew;
        logic div_start;
        logic div_step;
        logic err_upd;
        logic mul_p;
        logic mul_i;
        logic sum_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic blk_end;
        logic out_busy;
    } sts_t;

endpackage

### sv/vu_meter_ballistics.sv
// VU meter ballistics. When a sample is accepted, its magnitude is multiplied
// by the sensitivity gain and registered, then the slew-limited peak follower,
// block sum and sample count advance. A sample that ends a block (marked, or
// the MAX_BLOCK-th of the block) holds off the next sample while the divider
// is set up, a restoring divider forms the 17-bit quotient for the block level
// (one quotient bit per cycle), the PI needle update runs on one shared 24x17
// multiplier and the result register is loaded. That last step waits while a
// previous result is still held on the result channel. Configuration writes
// are accepted in every cycle and must only be issued while the block is idle.
module vu_meter_ballistics #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample,
    input  logic               s_last_in_block,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_needle_position,
    output logic [15:0]        m_block_level
);

    vmb_pkg::cfg_t cfg;
    vmb_pkg::cmd_t cmd;
    vmb_pkg::sts_t sts;

    vmb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vmb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vmb_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .cmd               (cmd),
        .sts               (sts),
        .s_sample          (s_sample),
        .s_last_in_block   (s_last_in_block),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_needle_position (m_needle_position),
        .m_block_level     (m_block_level)
    );

endmodule

### sv/vmb_regs.sv
module vmb_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output vmb_pkg::cfg_t cfg
);

    vmb_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sens_gain  <= vmb_pkg::SENS_GAIN_RST;
            cfg_reg.rise_step  <= vmb_pkg::RISE_STEP_RST;
            cfg_reg.fall_step  <= vmb_pkg::FALL_STEP_RST;
            cfg_reg.prop_coeff <= vmb_pkg::PROP_COEFF_RST;
            cfg_reg.int_coeff  <= vmb_pkg::INT_COEFF_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                vmb_pkg::REG_SENS_GAIN:  cfg_reg.sens_gain  <= cfg_data[14:0];
                vmb_pkg::REG_RISE_STEP:  cfg_reg.rise_step  <= cfg_data;
                vmb_pkg::REG_FALL_STEP:  cfg_reg.fall_step  <= cfg_data;
                vmb_pkg::REG_PROP_COEFF: cfg_reg.prop_coeff <= cfg_data;
                vmb_pkg::REG_INT_COEFF:  cfg_reg.int_coeff  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### sv/vmb_ctrl.sv
module vmb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vmb_pkg::sts_t sts,
    output vmb_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SLEW = 4'd1;
    localparam logic [3:0] S_DIVI = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_ERR  = 4'd4;
    localparam logic [3:0] S_MULP = 4'd5;
    localparam logic [3:0] S_MULI = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [4:0] LAST_STEP = 5'(vmb_pkg::DIV_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_prod = 1'b1;
                    state_next    = S_SLEW;
                end
            end
            S_SLEW: begin
                cmd.slew   = 1'b1;
                state_next = sts.blk_end ? S_DIVI : S_IDLE;
            end
            S_DIVI: begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 5'd1;
                if (step_reg == LAST_STEP) begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                cmd.err_upd = 1'b1;
                state_next  = S_MULP;
            end
            S_MULP: begin
                cmd.mul_p  = 1'b1;
                state_next = S_MULI;
            end
            S_MULI: begin
                cmd.mul_i  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum_step = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### sv/vmb_dp.sv
module vmb_dp #(
    parameter int MAX_BLOCK = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  vmb_pkg::cfg_t      cfg,
    input  vmb_pkg::cmd_t      cmd,
    output vmb_pkg::sts_t      sts,
    input  logic signed [15:0] s_sample,
    input  logic               s_last_in_block,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_needle_position,
    output logic [15:0]        m_block_level
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = vmb_pkg::PEAK_W + CNT_W;
    localparam int DIV_W = CNT_W + 25;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    localparam int PW = vmb_pkg::PEAK_W;
    localparam int IW = vmb_pkg::INTEG_W;
    localparam int QW = vmb_pkg::QUO_W;

    logic [30:0]                          prod_reg;
    logic                                 last_reg;
    logic [PW-1:0]                        pf_reg;
    logic [SUM_W-1:0]                     sum_reg;
    logic [CNT_W-1:0]                     cnt_reg;
    logic [DIV_W-1:0]                     num_reg;
    logic [DIV_W-1:0]                     den_reg;
    logic [QW-1:0]                        quo_reg;
    logic [15:0]                          level_reg;
    logic signed [17:0]                   err_reg;
    logic signed [IW-1:0]                 integ_reg;
    logic [15:0]                          pos_reg;
    logic signed [vmb_pkg::PROD_W-1:0]    mres_reg;
    logic signed [vmb_pkg::PROD_W-1:0]    pterm_reg;
    logic signed [vmb_pkg::STEP_W-1:0]    step_reg;
    logic                                 m_valid_reg;
    logic [15:0]                          m_pos_reg;
    logic [15:0]                          m_level_reg;

    logic [15:0]                          mag;
    logic [PW-1:0]                        x;
    logic [PW-1:0]                        dlt;
    logic [PW-1:0]                        pf_next;
    logic [SUM_W-1:0]                     sum_next;
    logic [CNT_W-1:0]                     cnt_next;
    logic [15:0]                          level;
    logic signed [17:0]                   err;
    logic signed [24:0]                   acc;
    logic signed [IW-1:0]                 integ_sat;
    logic signed [IW-1:0]                 mul_a;
    logic signed [16:0]                   mul_b;
    logic signed [vmb_pkg::PROD_W-1:0]    mul_res;
    logic signed [vmb_pkg::NP_W-1:0]      np;

    assign mag = s_sample[15] ? (~16'($unsigned(s_sample)) + 16'd1)
                              : 16'($unsigned(s_sample));

    assign x = PW'((prod_reg + 31'd32) >> 6);

    always_comb begin
        if (x >= pf_reg) begin
            dlt     = x - pf_reg;
            pf_next = pf_reg + ((dlt < PW'(cfg.rise_step)) ? dlt : PW'(cfg.rise_step));
        end else begin
            dlt     = pf_reg - x;
            pf_next = pf_reg - ((dlt < PW'(cfg.fall_step)) ? dlt : PW'(cfg.fall_step));
        end
    end

    assign sum_next = sum_reg + SUM_W'(pf_next);
    assign cnt_next = cnt_reg + CNT_W'(1);

    assign level = quo_reg[QW-1] ? 16'hFFFF : quo_reg[15:0];
    assign err   = $signed({2'b00, level}) - $signed({2'b00, pos_reg});
    assign acc   = 25'(integ_reg) + 25'(err);

    always_comb begin
        if (acc > vmb_pkg::INTEG_MAX) begin
            integ_sat = IW'(vmb_pkg::INTEG_MAX);
        end else if (acc < vmb_pkg::INTEG_MIN) begin
            integ_sat = IW'(vmb_pkg::INTEG_MIN);
        end else begin
            integ_sat = IW'(acc);
        end
    end

    assign mul_a   = cmd.mul_p ? IW'(err_reg) : integ_reg;
    assign mul_b   = cmd.mul_p ? $signed({1'b0, cfg.prop_coeff})
                               : $signed({1'b0, cfg.int_coeff});
    assign mul_res = mul_a * mul_b;

    assign np = $signed({11'b0, pos_reg}) + vmb_pkg::NP_W'($signed(step_reg[41:16]));

    assign sts.blk_end  = last_reg || (cnt_next >= MAX_CNT);
    assign sts.out_busy = m_valid_reg && !m_ready;

    assign m_valid           = m_valid_reg;
    assign m_needle_position = m_pos_reg;
    assign m_block_level     = m_level_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_prod) begin
            prod_reg <= 31'(mag) * 31'(cfg.sens_gain);
            last_reg <= s_last_in_block;
        end
        if (cmd.div_step) begin
            if (num_reg >= den_reg) begin
                num_reg <= num_reg - den_reg;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            den_reg <= den_reg >> 1;
        end else if (cmd.div_start) begin
            num_reg <= DIV_W'(sum_reg) + (DIV_W'(cnt_reg) << 7);
            den_reg <= DIV_W'(cnt_reg) << 24;
            quo_reg <= '0;
        end
        if (cmd.err_upd) begin
            level_reg <= level;
            err_reg   <= err;
        end
        if (cmd.mul_p || cmd.mul_i) begin
            mres_reg <= mul_res;
        end
        if (cmd.mul_i) begin
            pterm_reg <= mres_reg;
        end
        if (cmd.sum_step) begin
            step_reg <= vmb_pkg::STEP_W'(pterm_reg) + vmb_pkg::STEP_W'(mres_reg)
                      + 42'sd32768;
        end
        if (cmd.finish) begin
            m_level_reg <= level_reg;
            if (np <= 0) begin
                m_pos_reg <= '0;
            end else if (np >= vmb_pkg::NP_FULL) begin
                m_pos_reg <= vmb_pkg::FULL_SCALE;
            end else begin
                m_pos_reg <= np[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_reg      <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.slew) begin
                pf_reg  <= pf_next;
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end else if (cmd.div_start) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            if (cmd.err_upd) begin
                integ_reg <= integ_sat;
            end else if (cmd.finish) begin
                if (np <= 0) begin
                    pos_reg   <= '0;
                    integ_reg <= '0;
                end else if (np >= vmb_pkg::NP_FULL) begin
                    pos_reg   <= vmb_pkg::FULL_SCALE;
                    integ_reg <= '0;
                end else begin
                    pos_reg <= np[15:0];
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/vmb_checker.sv
module vmb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_needle_position,
    input logic [15:0] m_block_level
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_needle_position)
                                && $stable(m_block_level))
        else $error("result beat changed while stalled");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_needle_position <= 16'd32768)
        else $error("needle position beyond full scale");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a beat");

    a_result_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without block-end work");

endmodule

bind vu_meter_ballistics vmb_checker u_vmb_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_needle_position (m_needle_position),
    .m_block_level     (m_block_level)
);

### tb/sv/tb_vu_meter_ballistics.sv
`timescale 1ns / 1ps

module tb_vu_meter_ballistics;

    localparam int BLOCK_LIMIT    = 4096;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [15:0] position;
        logic [15:0] level;
    } meter_reading_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index       = vmb_pkg::REG_SENS_GAIN;
    logic [15:0]        cfg_data        = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample        = '0;
    logic               s_last_in_block = 1'b0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [15:0]        m_needle_position;
    logic [15:0]        m_block_level;

    vmb_pkg::cfg_t      meter_cfg;
    logic [23:0]        pk_follow;
    logic [35:0]        pk_sum;
    logic [12:0]        blk_count;
    logic [15:0]        needle_pos;
    logic signed [23:0] needle_integ;

    meter_reading_t     readings_due[$];
    meter_reading_t     head_reading;

    int mismatches      = 0;
    int samples_sent    = 0;
    int readings_seen   = 0;
    int cfg_writes      = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;
    int rdy_left        = 0;
    int rdy_mode        = 0;

    vu_meter_ballistics #(
        .MAX_BLOCK(BLOCK_LIMIT)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .s_last_in_block   (s_last_in_block),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_needle_position (m_needle_position),
        .m_block_level     (m_block_level)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic advance_meter(input logic signed [15:0] smp, input logic lst);
        logic [15:0]    mag;
        logic [31:0]    scaled;
        logic [23:0]    target;
        logic [23:0]    delta;
        longint         cnt;
        longint         lvl;
        longint         err;
        longint         acc;
        longint         stp;
        longint         np;
        meter_reading_t rd;
        mag = smp[15] ? (~smp + 16'd1) : smp;
        scaled = mag * meter_cfg.sens_gain + 32'd32;
        target = scaled[29:6];
        if (target >= pk_follow) begin
            delta = target - pk_follow;
            pk_follow = pk_follow + ((delta < meter_cfg.rise_step) ? delta : meter_cfg.rise_step);
        end else begin
            delta = pk_follow - target;
            pk_follow = pk_follow - ((delta < meter_cfg.fall_step) ? delta : meter_cfg.fall_step);
        end
        pk_sum = pk_sum + pk_follow;
        blk_count = blk_count + 13'd1;
        if (lst || blk_count >= BLOCK_LIMIT) begin
            cnt = longint'(blk_count);
            lvl = (longint'(pk_sum) + cnt * 128) / (cnt * 256);
            if (lvl > 65535) lvl = 65535;
            err = lvl - longint'(needle_pos);
            acc = longint'(needle_integ) + err;
            if (acc > longint'(vmb_pkg::INTEG_MAX)) acc = longint'(vmb_pkg::INTEG_MAX);
            if (acc < longint'(vmb_pkg::INTEG_MIN)) acc = longint'(vmb_pkg::INTEG_MIN);
            needle_integ = acc[23:0];
            stp = err * longint'(meter_cfg.prop_coeff) + acc * longint'(meter_cfg.int_coeff);
            np = longint'(needle_pos) + ((stp + 32768) >>> 16);
            if (np <= 0) begin
                needle_pos = '0;
                needle_integ = '0;
            end else if (np >= longint'(vmb_pkg::FULL_SCALE)) begin
                needle_pos = vmb_pkg::FULL_SCALE;
                needle_integ = '0;
            end else begin
                needle_pos = np[15:0];
            end
            rd.position = needle_pos;
            rd.level = lvl[15:0];
            readings_due.push_back(rd);
            pk_sum = '0;
            blk_count = '0;
        end
    endtask

    task automatic send_sample(input logic signed [15:0] smp, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 6);
                default: gap = $urandom_range(7, 40);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_sample <= smp;
        s_last_in_block <= lst;
        do @(posedge aclk); while (!s_ready);
        advance_meter(smp, lst);
        samples_sent++;
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            vmb_pkg::REG_SENS_GAIN:  meter_cfg.sens_gain = val[14:0];
            vmb_pkg::REG_RISE_STEP:  meter_cfg.rise_step = val;
            vmb_pkg::REG_FALL_STEP:  meter_cfg.fall_step = val;
            vmb_pkg::REG_PROP_COEFF: meter_cfg.prop_coeff = val;
            vmb_pkg::REG_INT_COEFF:  meter_cfg.int_coeff = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic program_regs(input logic [15:0] gain, input logic [15:0] rise,
                                input logic [15:0] fall, input logic [15:0] prop,
                                input logic [15:0] integ);
        reg_write(vmb_pkg::REG_SENS_GAIN, gain);
        reg_write(vmb_pkg::REG_RISE_STEP, rise);
        reg_write(vmb_pkg::REG_FALL_STEP, fall);
        reg_write(vmb_pkg::REG_PROP_COEFF, prop);
        reg_write(vmb_pkg::REG_INT_COEFF, integ);
        cfg_valid <= 1'b0;
    endtask

    // drain pending readings, then let the block finish any trailing sample
    task automatic settle();
        s_valid <= 1'b0;
        burst_left = 0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rnd_sample(input bit loud);
        logic [15:0] r;
        r = 16'($urandom);
        if (!loud) r = {{7{r[15]}}, r[8:0]};
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return r;
        endcase
    endfunction

    function automatic int rnd_len();
        if ($urandom_range(0, 7) == 0) return $urandom_range(32, 200);
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [15:0] rnd_reg();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_block(input int len, input bit loud);
        for (int i = 0; i < len; i++) send_sample(rnd_sample(loud), i == len - 1);
    endtask

    task automatic test_directed();
        send_sample(16'sh0000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        repeat (5) send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0000, 1'b1);
        send_sample(16'sh4000, 1'b1);
        send_sample(-16'sh4000, 1'b1);
        send_sample(16'sh5555, 1'b0);
        send_sample(-16'sh2AAB, 1'b1);
    endtask

    task automatic test_forced_block_end();
        for (int i = 0; i < BLOCK_LIMIT; i++) send_sample(rnd_sample(i[9]), 1'b0);
        send_block(3, 1'b1);
    endtask

    task automatic test_integrator_saturation();
        // park the needle mid-scale
        settle();
        program_regs(16'd16384, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        repeat (2) begin
            repeat (79) send_sample(16'sd16384, 1'b0);
            send_sample(16'sd16384, 1'b1);
        end
        // hold the needle, let the integrator run into its upper rail
        settle();
        program_regs(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        repeat (400) send_sample(16'sh8000, 1'b1);
        // release into full scale, then fall back to zero
        settle();
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1966, 16'hFFFF);
        repeat (4) send_sample(16'sh8000, 1'b1);
        repeat (20) send_sample(16'sh0000, 1'b1);
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int start;
        repeat (phases) begin
            settle();
            program_regs(rnd_reg(), rnd_reg(), rnd_reg(), rnd_reg(), rnd_reg());
            start = samples_sent;
            while (samples_sent - start < per_phase)
                send_block(rnd_len(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_reset_values();
        int start;
        settle();
        program_regs({1'b0, vmb_pkg::SENS_GAIN_RST}, vmb_pkg::RISE_STEP_RST,
                     vmb_pkg::FALL_STEP_RST, vmb_pkg::PROP_COEFF_RST,
                     vmb_pkg::INT_COEFF_RST);
        start = samples_sent;
        while (samples_sent - start < 200) send_block(rnd_len(), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rdy_left <= 0;
            rdy_mode <= 0;
        end else begin
            if (rdy_left == 0) begin
                rdy_mode <= $urandom_range(0, 3);
                rdy_left <= $urandom_range(10, 150);
            end else begin
                rdy_left <= rdy_left - 1;
            end
            case (rdy_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 7) == 0);
                default: m_ready <= (rdy_left % 16 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                $error("unexpected beat: needle_position %0d block_level %0d",
                       m_needle_position, m_block_level);
                mismatches++;
            end else begin
                head_reading = readings_due.pop_front();
                readings_seen++;
                if (m_needle_position !== head_reading.position) begin
                    $error("needle_position: expected %0d, actual %0d",
                           head_reading.position, m_needle_position);
                    mismatches++;
                end
                if (m_block_level !== head_reading.level) begin
                    $error("block_level: expected %0d, actual %0d",
                           head_reading.level, m_block_level);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        meter_cfg.sens_gain  = vmb_pkg::SENS_GAIN_RST;
        meter_cfg.rise_step  = vmb_pkg::RISE_STEP_RST;
        meter_cfg.fall_step  = vmb_pkg::FALL_STEP_RST;
        meter_cfg.prop_coeff = vmb_pkg::PROP_COEFF_RST;
        meter_cfg.int_coeff  = vmb_pkg::INT_COEFF_RST;
        pk_follow    = '0;
        pk_sum       = '0;
        blk_count    = '0;
        needle_pos   = '0;
        needle_integ = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_forced_block_end();
        test_integrator_saturation();
        test_random_settings(4, 150);
        test_reset_values();
        settle();

        if (readings_due.size() != 0) begin
            $error("%0d block readings never arrived", readings_due.size());
            mismatches++;
        end
        $display("%0d samples, %0d block readings checked, %0d register writes",
                 samples_sent, readings_seen, cfg_writes);
        $display("covered extremes, forced end at %0d samples, integrator rail, random settings",
                 BLOCK_LIMIT);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
